@@ sv/sls_pkg.sv @@
// shared types, constants and helpers for the serial led strip driver
package sls_pkg;

	// command codes
	localparam logic [2:0] FN_STORE_RGB    = 3'd0;
	localparam logic [2:0] FN_STORE_PACKED = 3'd1;
	localparam logic [2:0] FN_CLEAR        = 3'd2;
	localparam logic [2:0] FN_START        = 3'd3;
	localparam logic [2:0] FN_TICK         = 3'd4;

	// field widths
	localparam int FUNC_W  = 3;
	localparam int SLOT_W  = 8;
	localparam int CHAN_W  = 16;
	localparam int PACK_W  = 32;
	localparam int COLOR_W = 24;
	localparam int CFG_W   = 9;
	localparam int BCNT_W  = 8;
	localparam int WORD_W  = COLOR_W + 1;

	// frame timing
	localparam int LEAD_BITS  = 50;
	localparam int WORD_BITS  = 25;
	localparam int TRAIL_BITS = 200;

	localparam logic [7:0] BYTE_MAX = 8'd255;

	localparam int DEF_MAX_PIXELS = 256;
	localparam logic [CFG_W-1:0] NUM_PIXELS_RST = 9'd256;

	// write request toward the pixel store
	typedef struct packed {
		logic               set;
		logic               clr;
		logic [COLOR_W-1:0] color;
	} sls_wr_t;

	// one result item
	typedef struct packed {
		logic serial_data;
		logic clock_pulse;
		logic busy_res;
		logic frame_done;
		logic rejected;
	} sls_res_t;

	// saturate a 16 bit colour part to one byte
	function automatic logic [7:0] sat8(input logic [CHAN_W-1:0] v);
		sat8 = (v > CHAN_W'(BYTE_MAX)) ? BYTE_MAX : v[7:0];
	endfunction

endpackage

@@ sv/sls_ifs.sv @@
// request and result channel interfaces
interface sls_cmd_if import sls_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [SLOT_W-1:0] pixel_slot;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic [PACK_W-1:0] packed_color;

	modport source (output valid, func, pixel_slot, red, green, blue, packed_color,
		input ready);
	modport sink (input valid, func, pixel_slot, red, green, blue, packed_color,
		output ready);
endinterface

interface sls_res_if;
	logic valid;
	logic ready;
	logic serial_data;
	logic clock_pulse;
	logic busy_res;
	logic frame_done;
	logic rejected;

	modport source (output valid, serial_data, clock_pulse, busy_res, frame_done,
		rejected, input ready);
	modport sink (input valid, serial_data, clock_pulse, busy_res, frame_done,
		rejected, output ready);
endinterface

@@ sv/sls_store.sv @@
// pixel store: one-port-write, one-port-read memory with per-entry valid bits
module sls_store import sls_pkg::*; #(
	parameter int MAX_PIXELS = DEF_MAX_PIXELS,
	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sls_wr_t            wr,
	input  logic [AW-1:0]      wr_addr,
	input  logic [AW-1:0]      rd_addr,
	output logic [COLOR_W-1:0] rd_data
);

	logic [COLOR_W-1:0]    mem [MAX_PIXELS];
	logic [MAX_PIXELS-1:0] vld_q;
	logic [COLOR_W-1:0]    rd_word_q;
	logic                  rd_vld_q;

	// colour array write and registered read
	always_ff @(posedge clk) begin
		if (wr.set) begin
			mem[wr_addr] <= wr.color;
		end
		rd_word_q <= mem[rd_addr];
	end

	// valid bits: cleared entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.set) begin
				vld_q[wr_addr] <= 1'b1;
			end else if (wr.clr) begin
				vld_q[wr_addr] <= 1'b0;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

@@ sv/sls_ctrl.sv @@
// frame sequencer: command decode, bit counters, shift word and store access
module sls_ctrl import sls_pkg::*; #(
	parameter int MAX_PIXELS = DEF_MAX_PIXELS,
	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
	localparam int CW = $clog2(MAX_PIXELS + 1),
	localparam int EW = (CW > CFG_W) ? CW : CFG_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [FUNC_W-1:0]  func,
	input  logic [SLOT_W-1:0]  pixel_slot,
	input  logic [CHAN_W-1:0]  red,
	input  logic [CHAN_W-1:0]  green,
	input  logic [CHAN_W-1:0]  blue,
	input  logic [PACK_W-1:0]  packed_color,
	input  logic [CFG_W-1:0]   num_pixels,
	input  logic [COLOR_W-1:0] rd_data,
	output sls_wr_t            wr,
	output logic [AW-1:0]      wr_addr,
	output logic [AW-1:0]      rd_addr,
	output sls_res_t           res
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD,
		PH_PIXEL,
		PH_TRAIL,
		PH_CLEAR
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [BCNT_W-1:0]  bcnt_q, bcnt_d, bcnt_inc;
	logic [CW-1:0]      ptr_q, ptr_d, ptr_inc;
	logic [WORD_W-1:0]  shift_q, shift_d;
	logic [EW-1:0]      num_ext, n_ext;
	logic               busy;

	// live pixel count, capped at capacity
	assign num_ext = EW'(num_pixels);
	assign n_ext   = (num_ext > EW'(MAX_PIXELS)) ? EW'(MAX_PIXELS) : num_ext;

	assign busy     = (phase_q != PH_IDLE);
	assign bcnt_inc = bcnt_q + 1'b1;
	assign ptr_inc  = ptr_q + 1'b1;

	// prefetch the next pixel while a word is shifting, pixel zero otherwise
	assign rd_addr = (phase_q == PH_PIXEL) ? AW'(ptr_inc) : '0;

	// next state, store writes and result
	always_comb begin
		phase_d  = phase_q;
		bcnt_d   = bcnt_q;
		ptr_d    = ptr_q;
		shift_d  = shift_q;
		wr       = '0;
		wr_addr  = AW'(pixel_slot);
		res      = '0;
		if (fire) begin
			unique case (func)
				FN_STORE_RGB, FN_STORE_PACKED: begin
					if (busy || EW'(pixel_slot) >= n_ext) begin
						res.rejected = 1'b1;
					end else begin
						wr.set = 1'b1;
						if (func == FN_STORE_RGB) begin
							wr.color = {sat8(red), sat8(green), sat8(blue)};
						end else begin
							wr.color = packed_color[COLOR_W-1:0];
						end
					end
				end
				FN_CLEAR: begin
					if (busy) begin
						res.rejected = 1'b1;
					end else if (n_ext != '0) begin
						phase_d = PH_CLEAR;
						ptr_d   = '0;
					end
				end
				FN_START: begin
					if (busy) begin
						res.rejected = 1'b1;
					end else begin
						phase_d = PH_LEAD;
						bcnt_d  = '0;
						ptr_d   = '0;
					end
				end
				FN_TICK: begin
					unique case (phase_q)
						PH_LEAD: begin
							res.clock_pulse = 1'b1;
							bcnt_d = bcnt_inc;
							if (bcnt_inc >= BCNT_W'(LEAD_BITS)) begin
								bcnt_d = '0;
								ptr_d  = '0;
								if (n_ext != '0) begin
									shift_d = {1'b1, rd_data};
									phase_d = PH_PIXEL;
								end else begin
									phase_d = PH_TRAIL;
								end
							end
						end
						PH_PIXEL: begin
							res.clock_pulse = 1'b1;
							res.serial_data = shift_q[WORD_W-1];
							shift_d = {shift_q[WORD_W-2:0], 1'b0};
							bcnt_d  = bcnt_inc;
							if (bcnt_inc >= BCNT_W'(WORD_BITS)) begin
								bcnt_d = '0;
								ptr_d  = ptr_inc;
								if (EW'(ptr_inc) < n_ext) begin
									shift_d = {1'b1, rd_data};
								end else begin
									phase_d = PH_TRAIL;
								end
							end
						end
						PH_TRAIL: begin
							res.clock_pulse = 1'b1;
							bcnt_d = bcnt_inc;
							if (bcnt_inc >= BCNT_W'(TRAIL_BITS)) begin
								bcnt_d         = '0;
								res.frame_done = 1'b1;
								phase_d        = PH_IDLE;
							end
						end
						PH_CLEAR: begin
							wr_addr = AW'(ptr_q);
							wr.clr  = (EW'(ptr_q) < n_ext);
							ptr_d   = ptr_inc;
							if (EW'(ptr_inc) >= n_ext) begin
								ptr_d   = '0;
								phase_d = PH_IDLE;
							end
						end
						default: begin
							// idle tick changes nothing
						end
					endcase
				end
				default: begin
					res.rejected = 1'b1;
				end
			endcase
		end
		res.busy_res = (phase_d != PH_IDLE);
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bcnt_q  <= '0;
			ptr_q   <= '0;
			shift_q <= '0;
		end else begin
			phase_q <= phase_d;
			bcnt_q  <= bcnt_d;
			ptr_q   <= ptr_d;
			shift_q <= shift_d;
		end
	end

endmodule

@@ sv/serial_led_strip_driver_unit.sv @@
// top level of the serial led strip driver
//
//  channel | dir | handshake      | payload
//  cmd     | in  | valid / ready  | func, pixel_slot, red, green, blue, packed_color
//  res     | out | valid / ready  | serial_data, clock_pulse, busy_res, frame_done, rejected
//  cfg     | in  | cfg_we         | cfg_wdata = num_pixels
//
// one request per cycle unless stalled, each answered by one result from the output register.
// a frame takes 50 + 25 * pixels + 200 tick requests; a clear takes one tick per pixel.
// the next pixel is read from the store during the current 25 bit word, so ticks never wait.
// cmd.ready drops only while a result is held and res.ready is low.
// reset empties the store through its valid bits at once; no clearing pass.
module serial_led_strip_driver_unit import sls_pkg::*; #(
	parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	sls_cmd_if.sink          cmd,
	sls_res_if.source        res
);

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

	logic [CFG_W-1:0]   num_pixels_q;
	logic               fire;
	sls_wr_t            wr;
	logic [AW-1:0]      wr_addr;
	logic [AW-1:0]      rd_addr;
	logic [COLOR_W-1:0] rd_data;
	sls_res_t           res_d;
	sls_res_t           res_q;
	logic               res_vld_q;

	assign cmd.ready = !res_vld_q || res.ready;
	assign fire      = cmd.valid && cmd.ready;

	// pixel count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_pixels_q <= NUM_PIXELS_RST;
		end else if (cfg_we) begin
			num_pixels_q <= cfg_wdata;
		end
	end

	sls_ctrl #(.MAX_PIXELS(MAX_PIXELS)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.func         (cmd.func),
		.pixel_slot   (cmd.pixel_slot),
		.red          (cmd.red),
		.green        (cmd.green),
		.blue         (cmd.blue),
		.packed_color (cmd.packed_color),
		.num_pixels   (num_pixels_q),
		.rd_data      (rd_data),
		.wr           (wr),
		.wr_addr      (wr_addr),
		.rd_addr      (rd_addr),
		.res          (res_d)
	);

	sls_store #(.MAX_PIXELS(MAX_PIXELS)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (fire) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign res.valid       = res_vld_q;
	assign res.serial_data = res_q.serial_data;
	assign res.clock_pulse = res_q.clock_pulse;
	assign res.busy_res    = res_q.busy_res;
	assign res.frame_done  = res_q.frame_done;
	assign res.rejected    = res_q.rejected;

endmodule

@@ verif/tb_serial_led_strip_driver_unit.sv @@
// testbench for the serial led strip driver: random requests checked against a frame predictor
module tb_serial_led_strip_driver_unit;
	import sls_pkg::*;

	localparam int MAX_PIXELS  = DEF_MAX_PIXELS;
	localparam int STALL_LIMIT = 500;

	// function codes that the block does not know
	localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
	localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;

	typedef enum logic [2:0] {ST_IDLE, ST_LEAD, ST_PIXEL, ST_TRAIL, ST_CLEAR} strip_phase_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [SLOT_W-1:0] slot;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [PACK_W-1:0] packed_color;
	} strip_cmd_t;

	// tracks the pixel store and frame position, holds the expected line levels
	class led_frame_scoreboard;
		logic [COLOR_W-1:0] colors [MAX_PIXELS];
		logic [CFG_W-1:0]   strip_len;
		strip_phase_t       phase;
		int unsigned        bit_cnt;
		int unsigned        ptr;
		logic [WORD_W-1:0]  shifter;
		sls_res_t           bit_results_q[$];
		int                 errors;
		int                 results_seen;

		function new();
			foreach (colors[i])
				colors[i] = '0;
			strip_len = NUM_PIXELS_RST;
			phase = ST_IDLE;
			bit_cnt = 0;
			ptr = 0;
			shifter = '0;
			errors = 0;
			results_seen = 0;
		endfunction

		// counts above the store size act as the store size
		function int unsigned active_pixels();
			return (strip_len > MAX_PIXELS) ? MAX_PIXELS : strip_len;
		endfunction

		function logic [7:0] clip(logic [CHAN_W-1:0] v);
			return (v[CHAN_W-1:8] != '0) ? 8'hFF : v[7:0];
		endfunction

		// apply one accepted request and queue the line levels it must produce
		function void note_request(strip_cmd_t c);
			int unsigned n;
			logic        busy;
			sls_res_t    r;
			n = active_pixels();
			busy = (phase != ST_IDLE);
			r = '0;
			case (c.func)
				FN_STORE_RGB, FN_STORE_PACKED: begin
					if (busy || c.slot >= n)
						r.rejected = 1'b1;
					else if (c.func == FN_STORE_RGB)
						colors[c.slot] = {clip(c.red), clip(c.green), clip(c.blue)};
					else
						colors[c.slot] = c.packed_color[COLOR_W-1:0];
				end
				FN_CLEAR: begin
					if (busy) begin
						r.rejected = 1'b1;
					end else if (n > 0) begin
						phase = ST_CLEAR;
						ptr = 0;
					end
				end
				FN_START: begin
					if (busy) begin
						r.rejected = 1'b1;
					end else begin
						phase = ST_LEAD;
						bit_cnt = 0;
						ptr = 0;
					end
				end
				FN_TICK: begin
					case (phase)
						ST_LEAD: begin
							r.clock_pulse = 1'b1;
							bit_cnt++;
							if (bit_cnt >= LEAD_BITS) begin
								bit_cnt = 0;
								ptr = 0;
								if (n > 0) begin
									shifter = {1'b1, colors[0]};
									phase = ST_PIXEL;
								end else begin
									phase = ST_TRAIL;
								end
							end
						end
						ST_PIXEL: begin
							r.clock_pulse = 1'b1;
							r.serial_data = shifter[WORD_W-1];
							shifter = shifter << 1;
							bit_cnt++;
							if (bit_cnt >= WORD_BITS) begin
								bit_cnt = 0;
								ptr++;
								// live count decides whether another pixel follows
								if (ptr < n)
									shifter = {1'b1, colors[ptr]};
								else
									phase = ST_TRAIL;
							end
						end
						ST_TRAIL: begin
							r.clock_pulse = 1'b1;
							bit_cnt++;
							if (bit_cnt >= TRAIL_BITS) begin
								bit_cnt = 0;
								r.frame_done = 1'b1;
								phase = ST_IDLE;
							end
						end
						ST_CLEAR: begin
							if (ptr < n)
								colors[ptr] = '0;
							ptr++;
							if (ptr >= n) begin
								ptr = 0;
								phase = ST_IDLE;
							end
						end
						default: ;
					endcase
				end
				default: r.rejected = 1'b1;
			endcase
			r.busy_res = (phase != ST_IDLE);
			bit_results_q.push_back(r);
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_result(sls_res_t got);
			sls_res_t want;
			results_seen++;
			if (bit_results_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result %0d arrived with no request waiting: %b",
						$time, results_seen, got);
				return;
			end
			want = bit_results_q.pop_front();
			if (got.serial_data !== want.serial_data || got.clock_pulse !== want.clock_pulse ||
					got.busy_res !== want.busy_res || got.frame_done !== want.frame_done ||
					got.rejected !== want.rejected) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result %0d exp %b%b%b%b%b got %b%b%b%b%b",
						$time, results_seen, want.serial_data, want.clock_pulse,
						want.busy_res, want.frame_done, want.rejected, got.serial_data,
						got.clock_pulse, got.busy_res, got.frame_done, got.rejected);
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	logic             rcv_ready = 1'b0;

	sls_cmd_if cmd();
	sls_res_if res();

	led_frame_scoreboard sb;
	int burst_left;
	int stall_run = 0;
	int rcv_cycle = 0;
	int rcv_mode = 0;

	serial_led_strip_driver_unit #(.MAX_PIXELS(MAX_PIXELS)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.res      (res)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	assign res.ready = rcv_ready;

	// result side stall pattern, mode picked again at random now and then
	always @(posedge clk) begin
		rcv_cycle <= rcv_cycle + 1;
		if (rcv_cycle % 128 == 0)
			rcv_mode <= $urandom_range(0, 2);
		case (rcv_mode)
			0: rcv_ready <= 1'b1;
			1: rcv_ready <= 1'($urandom_range(0, 1));
			default: rcv_ready <= (rcv_cycle % 5 == 0);
		endcase
	end

	// result checking
	always @(posedge clk) begin
		if (arst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1)
			sb.check_result(sls_res_t'{res.serial_data, res.clock_pulse, res.busy_res,
				res.frame_done, res.rejected});
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((cmd.valid === 1'b1 && cmd.ready === 1'b1) ||
				(res.valid === 1'b1 && res.ready === 1'b1))
			stall_run <= 0;
		else
			stall_run <= stall_run + 1;
		if (stall_run >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [CHAN_W-1:0] rand_chan();
		case ($urandom_range(0, 3))
			0: return CHAN_W'($urandom_range(0, 255));
			1: return CHAN_W'($urandom_range(254, 257));
			2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return CHAN_W'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	// mostly valid indexes, now and then anything
	function automatic logic [SLOT_W-1:0] random_slot();
		int unsigned n;
		n = sb.active_pixels();
		if (n > 0 && $urandom_range(0, 7) != 0)
			return SLOT_W'($urandom_range(0, n - 1));
		return SLOT_W'($urandom_range(0, 255));
	endfunction

	function automatic strip_cmd_t make_cmd(logic [FUNC_W-1:0] f, logic [SLOT_W-1:0] slot);
		strip_cmd_t c;
		c.func = f;
		c.slot = slot;
		c.red = rand_chan();
		c.green = rand_chan();
		c.blue = rand_chan();
		c.packed_color = $urandom();
		return c;
	endfunction

	// unknown function codes
	function automatic logic [FUNC_W-1:0] unknown_func();
		return FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
	endfunction

	// commands that a busy block must refuse, plus unknown codes
	function automatic logic [FUNC_W-1:0] noise_func();
		if ($urandom_range(0, 3) == 0)
			return unknown_func();
		return FUNC_W'($urandom_range(FN_STORE_RGB, FN_START));
	endfunction

	// one request, sent in bursts with random gaps between them
	task automatic send_cmd(strip_cmd_t c);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				cmd.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 40);
		end
		cmd.valid <= 1'b1;
		cmd.func <= c.func;
		cmd.pixel_slot <= c.slot;
		cmd.red <= c.red;
		cmd.green <= c.green;
		cmd.blue <= c.blue;
		cmd.packed_color <= c.packed_color;
		do
			@(posedge clk);
		while (cmd.ready !== 1'b1);
		sb.note_request(c);
		burst_left--;
	endtask

	// stop requests and wait for every result
	task automatic drain_requests();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (sb.bit_results_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_len(logic [CFG_W-1:0] v);
		drain_requests();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.strip_len = v;
	endtask

	// tick until the frame or clear ends, with refused commands mixed in;
	// optionally change the pixel count after change_at ticks
	task automatic run_until_idle(int change_at, logic [CFG_W-1:0] new_len);
		int ticks;
		ticks = 0;
		while (sb.phase != ST_IDLE) begin
			if (ticks == change_at)
				set_len(new_len);
			if ($urandom_range(0, 24) == 0)
				send_cmd(make_cmd(noise_func(), random_slot()));
			else
				send_cmd(make_cmd(FN_TICK, random_slot()));
			ticks++;
		end
	endtask

	initial begin
		strip_cmd_t       c;
		logic [CFG_W-1:0] len_plan [4];
		int               roll;

		len_plan = '{9'd3, 9'd0, 9'd511, 9'd6};
		sb = new();
		burst_left = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cmd.valid = 1'b0;
		cmd.func = FN_TICK;
		cmd.pixel_slot = '0;
		cmd.red = '0;
		cmd.green = '0;
		cmd.blue = '0;
		cmd.packed_color = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// colour saturation and masking at the store edges
		c = make_cmd(FN_STORE_RGB, 8'd0);
		c.red = 16'hFFFF;
		c.green = 16'h00FF;
		c.blue = 16'h0100;
		send_cmd(c);
		c = make_cmd(FN_STORE_RGB, 8'd255);
		c.red = 16'h0000;
		c.green = 16'h00FE;
		c.blue = 16'h8000;
		send_cmd(c);
		c = make_cmd(FN_STORE_PACKED, 8'd1);
		c.packed_color = 32'hFFFF_FFFF;
		send_cmd(c);
		c = make_cmd(FN_STORE_PACKED, 8'd2);
		c.packed_color = 32'hFF00_0000;
		send_cmd(c);
		c = make_cmd(FN_STORE_PACKED, 8'd128);
		c.packed_color = 32'h00A5_5A0F;
		send_cmd(c);

		// unknown codes and a tick while idle
		send_cmd(make_cmd(FN_UNUSED_LO, 8'd0));
		send_cmd(make_cmd(FN_UNUSED_LO + 3'd1, 8'd0));
		send_cmd(make_cmd(FN_UNUSED_HI, 8'd0));
		send_cmd(make_cmd(FN_TICK, 8'd0));

		// short clear with commands refused meanwhile
		set_len(9'd4);
		send_cmd(make_cmd(FN_CLEAR, 8'd0));
		send_cmd(make_cmd(FN_STORE_PACKED, 8'd1));
		send_cmd(make_cmd(FN_START, 8'd0));
		send_cmd(make_cmd(FN_CLEAR, 8'd0));
		run_until_idle(-1, '0);

		// empty strip: clear ends at once, stores refused
		set_len(9'd0);
		send_cmd(make_cmd(FN_CLEAR, 8'd0));
		send_cmd(make_cmd(FN_STORE_RGB, 8'd0));

		// count above capacity acts as capacity
		set_len(9'd300);
		send_cmd(make_cmd(FN_STORE_PACKED, 8'd2));
		send_cmd(make_cmd(FN_STORE_RGB, 8'd255));

		// two pixel strip, index out of range, count raised to three during the frame
		set_len(9'd2);
		send_cmd(make_cmd(FN_STORE_RGB, 8'd2));
		send_cmd(make_cmd(FN_STORE_RGB, 8'd0));
		send_cmd(make_cmd(FN_STORE_PACKED, 8'd1));
		send_cmd(make_cmd(FN_START, 8'd0));
		send_cmd(make_cmd(FN_STORE_RGB, 8'd0));
		run_until_idle(60, 9'd3);

		// random stores, idle ticks, unknown codes and short clears over several lengths
		for (int ph = 0; ph < 4; ph++) begin
			set_len(len_plan[ph]);
			for (int k = 0; k < 12; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 60) begin
					send_cmd(make_cmd($urandom_range(0, 1) ? FN_STORE_PACKED : FN_STORE_RGB,
						random_slot()));
				end else if (roll < 85) begin
					send_cmd(make_cmd($urandom_range(0, 1) ? FN_TICK : unknown_func(),
						SLOT_W'($urandom_range(0, 255))));
				end else if (sb.active_pixels() <= 8) begin
					send_cmd(make_cmd(FN_CLEAR, random_slot()));
					run_until_idle(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : -1,
						CFG_W'($urandom_range(0, 6)));
				end
			end
		end

		drain_requests();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.bit_results_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/sls_pkg.sv
sv/sls_ifs.sv
sv/sls_store.sv
sv/sls_ctrl.sv
sv/serial_led_strip_driver_unit.sv
verif/tb_serial_led_strip_driver_unit.sv
